### src/daie_pkg.sv
// ----------------------------------------------------------------------------
// daie_pkg
// Shared constants and types for the ascii int16 extractor.
// ----------------------------------------------------------------------------
package daie_pkg;

  localparam int unsigned MagW   = 16;
  localparam int unsigned CountW = 3;
  // wide enough for a 16-bit magnitude times ten plus a digit
  localparam int unsigned ProdW  = 20;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2d;

  localparam logic [ProdW-1:0]  MaxPosMag  = ProdW'(32767);
  localparam logic [ProdW-1:0]  MaxNegMag  = ProdW'(32768);
  localparam logic [CountW-1:0] FullDigits = CountW'(4);

  typedef logic [MagW-1:0]   mag_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [ProdW-1:0]  prod_t;

  // one result item as held in the output register
  typedef struct packed {
    logic [MagW-1:0] value;
    logic            found;
    logic            eot;
  } result_t;

endpackage

### src/dirty_ascii_int16_extractor.sv
// ----------------------------------------------------------------------------
// dirty_ascii_int16_extractor
// Pulls signed 16-bit decimal numbers out of a stream of ascii bytes.
// ----------------------------------------------------------------------------
// usage:
//   input channel (text_byte_i, in_valid_i/in_ready_o) takes one ascii byte
//   per transfer; byte zero marks the end of the text
//   output channel (number_value_o, number_found_o, end_of_text_o,
//   out_valid_o/out_ready_i) gives at most one result per input byte
//   a result is registered and appears in the cycle after the byte that causes it
//   throughput: one byte per cycle while in_ready_o is high; the parse state is
//   updated in the same cycle that a byte is taken, so there is no feedback stall
//   a single output register holds a finished result; the input side keeps
//   taking bytes while it is empty or being drained in the same cycle
//   receiver stall: once the output register holds an untaken result,
//   in_ready_o drops until out_ready_i takes it
//   reset: accumulator, digit count and minus flag clear, output empty
// ----------------------------------------------------------------------------
module dirty_ascii_int16_extractor
  import daie_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        text_byte_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic signed [15:0] number_value_o,
  output logic              number_found_o,
  output logic              end_of_text_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  // parse state
  mag_t    mag_q, mag_d;
  count_t  cnt_q, cnt_d;
  logic    minus_q, minus_d;

  // output register
  result_t res_q, res_d;
  logic    out_valid_q, out_valid_d;
  logic    emit;

  logic    in_xfer;
  logic    have;
  logic    is_digit;
  logic [3:0] digit;
  prod_t   next_mag;
  prod_t   limit;
  mag_t    emit_mag;

  // output register free or being emptied this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign have     = (cnt_q != '0);
  assign is_digit = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
  assign digit    = 4'(text_byte_i - CharZero);

  // mag * 10 + digit as (mag << 3) + (mag << 1) + digit
  assign next_mag = (prod_t'(mag_q) << 3) + (prod_t'(mag_q) << 1) + prod_t'(digit);
  assign limit    = minus_q ? MaxNegMag : MaxPosMag;

  always_comb begin
    mag_d    = mag_q;
    cnt_d    = cnt_q;
    minus_d  = minus_q;
    emit     = 1'b0;
    emit_mag = mag_q;
    res_d    = '0;

    if (in_xfer) begin
      priority if (text_byte_i == CharNul) begin
        // end of text: flush whatever is pending
        emit    = 1'b1;
        res_d.found = have;
        res_d.eot   = 1'b1;
        mag_d   = '0;
        cnt_d   = '0;
        minus_d = 1'b0;
      end else if (!is_digit) begin
        // junk ends a number; a minus arms the next one
        emit        = have;
        res_d.found = 1'b1;
        mag_d   = '0;
        cnt_d   = '0;
        minus_d = (text_byte_i == CharMinus);
      end else if (cnt_q >= FullDigits) begin
        emit        = 1'b1;
        res_d.found = 1'b1;
        if (next_mag <= limit) begin
          // fifth digit fits
          emit_mag = next_mag[MagW-1:0];
          mag_d    = '0;
          cnt_d    = '0;
          minus_d  = 1'b0;
        end else begin
          // overflow: four-digit number out, digit starts a fresh one
          mag_d   = mag_t'(digit);
          cnt_d   = count_t'(1);
          minus_d = 1'b0;
        end
      end else begin
        mag_d = next_mag[MagW-1:0];
        cnt_d = cnt_q + count_t'(1);
      end
    end

    if (res_d.found) begin
      res_d.value = minus_q ? (mag_t'(0) - emit_mag) : emit_mag;
    end

    // load a new result, drain an old one, or hold
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      cnt_q       <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      cnt_q       <= cnt_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign number_value_o = signed'(res_q.value);
  assign number_found_o = res_q.found;
  assign end_of_text_o  = res_q.eot;

endmodule

### src/daie_checker.sv
// ----------------------------------------------------------------------------
// daie_checker
// Port-level checks for the ascii int16 extractor, bound to the top level.
// ----------------------------------------------------------------------------
module daie_checker
  import daie_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic [7:0]        text_byte_i,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic signed [15:0] number_value_o,
  input logic              number_found_o,
  input logic              end_of_text_o,
  input logic              out_valid_o,
  input logic              out_ready_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(number_value_o)
      && $stable(number_found_o) && $stable(end_of_text_o))
    else $error("stalled result changed");

  // empty result carries a zero value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !number_found_o |-> number_value_o == 16'sd0)
    else $error("empty result with nonzero value");

  // terminator always yields an end-marked result next cycle
  a_nul_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && text_byte_i == CharNul |=> out_valid_o && end_of_text_o)
    else $error("terminator without end mark");

  // empty output register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind dirty_ascii_int16_extractor daie_checker u_daie_checker (.*);

### tb/sv/tb_dirty_ascii_int16_extractor.sv
// ----------------------------------------------------------------------------
// tb_dirty_ascii_int16_extractor
// Self-checking bench for the ascii int16 extractor: a short table of
// directed bytes (empty text, the int16 limits, fifth-digit overflow, minus
// handling, bytes next to the digit range, high bytes), then random text made
// of numbers, separators and noise. Each accepted byte goes through a local
// parse model and the results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_dirty_ascii_int16_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import daie_pkg::*;

  localparam int unsigned DirN       = 25;
  localparam int unsigned RandBytes  = 1700;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned PrintCap   = 30;

  localparam result_t NoRes = '0;

  // receiver behavior, picked at random each time rx_left runs out
  typedef enum logic [1:0] {RxOpen, RxCoin, RxChoke, RxPulse} rx_mode_e;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    result_t    want;
  } text_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [7:0]        text_byte_i = CharNul;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic signed [15:0] number_value_o;
  logic              number_found_o;
  logic              end_of_text_o;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;

  // parse state of the local model
  mag_t   acc_mag;
  count_t digit_cnt;
  bit     neg_flag;

  result_t     number_q [$];
  logic [7:0]  text_q [$];

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned res_cnt      = 0;
  int unsigned num_cnt      = 0;
  int unsigned neg_cnt      = 0;
  int unsigned eot_cnt      = 0;
  int unsigned split_cnt    = 0;

  rx_mode_e    rx_mode      = RxOpen;
  int unsigned rx_left      = 0;
  int unsigned pulse_ph     = 0;

  int unsigned corner_vals [13] = '{0, 1, 9, 10, 3276, 9999, 10000, 32766, 32767,
                                    32768, 32769, 65535, 99999};

  // directed text; expected results typed in where they are obvious,
  // the other result rows come from the model
  text_row_t dir_rows [DirN] = '{
    '{CharNul,   1'b1, '{16'd0, 1'b0, 1'b1}},      // empty text right after reset
    '{CharMinus, 1'b0, NoRes},
    '{"3",       1'b0, NoRes},
    '{"2",       1'b0, NoRes},
    '{"7",       1'b0, NoRes},
    '{"6",       1'b0, NoRes},
    '{"8",       1'b1, '{16'h8000, 1'b1, 1'b0}},   // most negative fits on digit five
    '{"3",       1'b0, NoRes},
    '{"2",       1'b0, NoRes},
    '{"7",       1'b0, NoRes},
    '{"6",       1'b0, NoRes},
    '{"7",       1'b1, '{16'd32767, 1'b1, 1'b0}},  // most positive fits
    '{"9",       1'b0, NoRes},
    '{"9",       1'b0, NoRes},
    '{"9",       1'b0, NoRes},
    '{"9",       1'b0, NoRes},
    '{"9",       1'b1, '{16'd9999, 1'b1, 1'b0}},   // overflow: four digits out
    '{CharMinus, 1'b0, NoRes},                     // ends the leftover 9, arms minus
    '{"5",       1'b0, NoRes},
    '{8'h3a,     1'b0, NoRes},                     // just above '9' ends -5
    '{8'h2f,     1'b0, NoRes},                     // just below '0'
    '{CharMinus, 1'b0, NoRes},
    '{8'h80,     1'b0, NoRes},                     // high byte cancels the minus
    '{"7",       1'b0, NoRes},
    '{CharNul,   1'b1, '{16'd7, 1'b1, 1'b1}}       // pending number with end mark
  };

  dirty_ascii_int16_extractor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_byte_i    (text_byte_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .number_value_o (number_value_o),
    .number_found_o (number_found_o),
    .end_of_text_o  (end_of_text_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  always #4 clk_i = ~clk_i;

  // two's complement of the magnitude when the minus is armed
  function automatic mag_t signed_number();
    return neg_flag ? mag_t'(-acc_mag) : acc_mag;
  endfunction

  function automatic void clear_number();
    acc_mag   = '0;
    digit_cnt = '0;
    neg_flag  = 1'b0;
  endfunction

  // advance the model by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] ch, output result_t res);
    bit    have;
    prod_t grown;
    prod_t cap;
    have = (digit_cnt != '0);
    res  = NoRes;
    if (ch == CharNul) begin
      res.eot   = 1'b1;
      res.found = have;
      res.value = have ? signed_number() : '0;
      clear_number();
      return 1'b1;
    end
    if (ch < CharZero || ch > CharNine) begin
      if (have) begin
        res.found = 1'b1;
        res.value = signed_number();
      end
      acc_mag   = '0;
      digit_cnt = '0;
      neg_flag  = (ch == CharMinus);
      return have;
    end
    grown = prod_t'(acc_mag) * prod_t'(10) + prod_t'(ch - CharZero);
    if (digit_cnt >= FullDigits) begin
      cap       = neg_flag ? MaxNegMag : MaxPosMag;
      res.found = 1'b1;
      if (grown <= cap) begin
        acc_mag   = grown[MagW-1:0];
        res.value = signed_number();
        clear_number();
      end else begin
        // four-digit number goes out, the digit opens a new positive one
        res.value = signed_number();
        acc_mag   = mag_t'(ch - CharZero);
        digit_cnt = count_t'(1);
        neg_flag  = 1'b0;
        split_cnt++;
      end
      return 1'b1;
    end
    acc_mag   = grown[MagW-1:0];
    digit_cnt = digit_cnt + count_t'(1);
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintCap)
      $display("[%0t] mismatch on %s: got %0d, want %0d (result %0d)",
               $realtime, what, got, want, res_cnt);
  endtask

  // one random token: a number with an optional separator, or a few noise bytes
  task automatic add_token();
    int unsigned pick;
    int unsigned v;
    int unsigned lead;
    int          i;
    string       digits;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        text_q.push_back(CharMinus);
        // now and then junk between the minus and the digits
        if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      end
      if (pick < 55) v = corner_vals[$urandom_range(0, 12)];
      else           v = $urandom % (10 ** $urandom_range(1, 5));
      lead = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
      repeat (lead) text_q.push_back(CharZero);
      digits = $sformatf("%0d", v);
      for (i = 0; i < digits.len(); i++) text_q.push_back(digits[i]);
      case ($urandom_range(0, 9))
        0, 1:    text_q.push_back(CharNul);
        2:       text_q.push_back(CharMinus);
        3:       text_q.push_back(8'h2f);
        4:       text_q.push_back(8'h3a);
        5:       text_q.push_back(" ");
        6:       text_q.push_back(",");
        7:       text_q.push_back(8'($urandom_range(0, 255)));
        default: ;  // no separator, digits run into the next token
      endcase
    end
  endtask

  // offer one byte, wait for the transfer, then maybe open a gap
  task automatic drive_byte(input logic [7:0] ch, input bit typed, input result_t want);
    result_t res;
    text_byte_i <= ch;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (parse_byte(ch, res) || typed) number_q.push_back(typed ? want : res);
    bytes_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    pulse_ph <= pulse_ph + 1;
    case (rx_mode)
      RxOpen:  out_ready_i <= 1'b1;
      RxCoin:  out_ready_i <= $urandom_range(0, 1);
      RxChoke: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (pulse_ph % 3 == 0);
    endcase
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_cnt++;
      if (number_found_o) begin
        num_cnt++;
        if (number_value_o < 0) neg_cnt++;
      end
      if (end_of_text_o) eot_cnt++;
      if (number_q.size() == 0) begin
        report_mismatch("unexpected result, value", int'(number_value_o), 0);
      end else begin
        want = number_q.pop_front();
        if (number_value_o !== want.value)
          report_mismatch("number_value", int'(number_value_o), int'($signed(want.value)));
        if (number_found_o !== want.found)
          report_mismatch("number_found", int'(number_found_o), int'(want.found));
        if (end_of_text_o !== want.eot)
          report_mismatch("end_of_text", int'(end_of_text_o), int'(want.eot));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, number_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned k;
    clear_number();
    while (text_q.size() < RandBytes) add_token();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DirN; k++) drive_byte(dir_rows[k].ch, dir_rows[k].typed, dir_rows[k].want);
    while (text_q.size() != 0) drive_byte(text_q.pop_front(), 1'b0, NoRes);
    in_valid_i <= 1'b0;

    while (number_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d bytes (%0d directed), checked %0d results", bytes_sent, DirN, res_cnt);
    $display("numbers %0d (negative %0d), end marks %0d, overflow splits %0d",
             num_cnt, neg_cnt, eot_cnt, split_cnt);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/daie_pkg.sv
src/dirty_ascii_int16_extractor.sv
src/daie_checker.sv
tb/sv/tb_dirty_ascii_int16_extractor.sv
